// ----- hdl/sql_statement_splitter_macros.svh -----
// Assertion macros shared by the splitter modules.
// Each macro names the clock and the active-low reset that disables the check.
`ifndef SQL_STATEMENT_SPLITTER_MACROS_SVH
`define SQL_STATEMENT_SPLITTER_MACROS_SVH
`ifndef SYNTHESIS
`define SSS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("splitter assertion failed");
`define SSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("splitter assertion failed");
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("splitter assertion failed");
`else
`define SSS_ASSERT(label, clk, rst_n, prop)
`define SSS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/sss_pkg.sv -----
package sss_pkg;

    localparam logic       KIND_DATA = 1'b0;
    localparam logic       KIND_END  = 1'b1;

    localparam logic [7:0] C_SEMICOLON = 8'h3B;
    localparam logic [7:0] C_QUOTE     = 8'h27;
    localparam logic [7:0] C_BACKSLASH = 8'h5C;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_PART_LIMIT = 2'd1;
    localparam logic [1:0] ST_CAP        = 2'd2;

    localparam logic [23:0] C_PART_MAX       = 24'hFFFFFF;
    localparam logic [31:0] C_MAX_PART_RESET = 32'd1048576;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [30:0] statement_length;
        logic [23:0] part_index;
        logic [31:0] part_offset;
        logic        new_part;
        logic [1:0]  status;
        logic        is_final;
    } t_out_word;

    // One ended statement, handed from the front end to the placement logic.
    typedef struct packed {
        logic [30:0] length;
        logic        is_final;
        logic        cap_hit;
    } t_stmt_evt;

    // Queue status seen by the two sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

// ----- hdl/sql_statement_splitter.sv -----
// Throughput: one input word per cycle while the event queue is not full; one result
// word per cycle from the output register while i_out_stall is low.
// A run of results faster than the consumer takes them is absorbed by the event queue.
// Reset is synchronous and active low; it clears all stream and part state and
// restores max_part_bytes to 1048576. A halt after an error lasts until reset.
module sql_statement_splitter import sss_pkg::*; #(
    parameter int STATEMENT_CAP_BYTES = 1073741824,
    parameter int QUEUE_DEPTH         = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    input  t_in_word    i_in_word,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_word   o_out_word,
    input  logic        i_out_stall
);

    // The front end runs the escape and quote tracker on every input word and
    // counts statement bytes. Each ended statement, end of input, or a cap
    // overflow becomes one event in a short queue. The front end stalls its
    // input only when that queue is full.
    //
    // The back end pops one event per cycle whenever its output register is
    // empty or being taken, places the statement into the current part with
    // one wide add and two compares against max_part_bytes, and loads the result
    // word. After any error it stops producing results and drains the queue.

    t_queue_stat q_stat;
    t_stmt_evt   push_evt;
    t_stmt_evt   head_evt;
    logic        push;
    logic        pop;

    sss_front #(
        .STATEMENT_CAP_BYTES(STATEMENT_CAP_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_push_evt (push_evt)
    );

    sss_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_evt (push_evt),
        .i_pop      (pop),
        .o_head     (head_evt),
        .o_stat     (q_stat)
    );

    sss_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_head        (head_evt),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .o_out_word    (o_out_word),
        .i_out_stall   (i_out_stall)
    );

endmodule

// ----- hdl/sss_front.sv -----
module sss_front import sss_pkg::*; #(
    parameter int STATEMENT_CAP_BYTES = 1073741824
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_word    i_in_word,
    output logic        o_in_stall,
    input  t_queue_stat i_q_stat,
    output logic        o_push,
    output t_stmt_evt   o_push_evt
);

    localparam logic [30:0] CAP = 31'(STATEMENT_CAP_BYTES);

    logic        r_inside_quote, n_inside_quote;
    logic        r_escape, n_escape;
    logic [30:0] r_count, n_count;
    logic        r_halted, n_halted;
    logic        accept;
    logic        ends;
    logic [30:0] count_inc;

    // Once halted every word is swallowed.
    assign o_in_stall = i_q_stat.full && !r_halted;
    assign accept     = i_in_valid && !o_in_stall;
    assign count_inc  = r_count + 31'd1;

    always_comb begin
        n_inside_quote = r_inside_quote;
        n_escape       = r_escape;
        n_count        = r_count;
        n_halted       = r_halted;
        o_push         = 1'b0;
        o_push_evt     = '{length: r_count, is_final: 1'b0, cap_hit: 1'b0};
        ends           = 1'b0;
        if (accept && !r_halted) begin
            if (i_in_word.kind == KIND_END) begin
                o_push          = 1'b1;
                o_push_evt.is_final = 1'b1;
                n_inside_quote  = 1'b0;
                n_escape        = 1'b0;
                n_count         = '0;
            end else begin
                if (r_escape) begin
                    n_escape = 1'b0;
                end else if (i_in_word.data_byte == C_BACKSLASH) begin
                    n_escape = 1'b1;
                end else if (i_in_word.data_byte == C_QUOTE) begin
                    n_inside_quote = !r_inside_quote;
                end else if (i_in_word.data_byte == C_SEMICOLON && !r_inside_quote) begin
                    ends = 1'b1;
                end
                n_count = count_inc;
                if (count_inc > CAP) begin
                    o_push             = 1'b1;
                    o_push_evt.length  = count_inc;
                    o_push_evt.cap_hit = 1'b1;
                    n_halted           = 1'b1;
                end else if (ends) begin
                    o_push            = 1'b1;
                    o_push_evt.length = count_inc;
                    n_count           = '0;
                    n_inside_quote    = 1'b0;
                    n_escape          = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside_quote <= 1'b0;
            r_escape       <= 1'b0;
            r_count        <= '0;
            r_halted       <= 1'b0;
        end else begin
            r_inside_quote <= n_inside_quote;
            r_escape       <= n_escape;
            r_count        <= n_count;
            r_halted       <= n_halted;
        end
    end

endmodule

// ----- hdl/sss_queue.sv -----
module sss_queue import sss_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_stmt_evt   i_push_evt,
    input  logic        i_pop,
    output t_stmt_evt   o_head,
    output t_queue_stat o_stat
);
`include "sql_statement_splitter_macros.svh"

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    t_stmt_evt     r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == FULL_COUNT);
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `SSS_ASSERT_IMPL(a_no_push_when_full, i_clk, i_rst_n, i_push, !o_stat.full)
    `SSS_ASSERT_IMPL(a_no_pop_when_empty, i_clk, i_rst_n, i_pop, !o_stat.empty)
    `SSS_ASSERT(a_count_bounded, i_clk, i_rst_n, r_count <= FULL_COUNT)

endmodule

// ----- hdl/sss_back.sv -----
module sss_back import sss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  t_stmt_evt   i_head,
    input  t_queue_stat i_q_stat,
    output logic        o_pop,
    output logic        o_out_valid,
    output t_out_word   o_out_word,
    input  logic        i_out_stall
);
`include "sql_statement_splitter_macros.svh"

    logic [31:0] r_max_part;
    logic [31:0] r_fill, n_fill;
    logic [23:0] r_part, n_part;
    logic        r_halted, n_halted;
    logic        r_out_valid, n_out_valid;
    t_out_word   r_out_word, n_out_word;
    logic [32:0] len_ext;
    logic [32:0] sum;

    assign o_pop       = !i_q_stat.empty && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign len_ext     = {2'b00, i_head.length};
    assign sum         = len_ext + {1'b0, r_fill};

    always_comb begin
        n_fill      = r_fill;
        n_part      = r_part;
        n_halted    = r_halted;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        if (o_pop && !r_halted) begin
            n_out_valid = 1'b1;
            n_out_word  = '{statement_length: i_head.length, part_index: r_part,
                            part_offset: r_fill, new_part: 1'b0, status: ST_OK,
                            is_final: i_head.is_final};
            if (i_head.cap_hit) begin
                n_out_word.status = ST_CAP;
                n_halted          = 1'b1;
            end else if (len_ext > {1'b0, r_max_part}) begin
                n_out_word.status = ST_PART_LIMIT;
                n_halted          = 1'b1;
            end else begin
                if (sum > {1'b0, r_max_part}) begin
                    if (r_part != C_PART_MAX) begin
                        n_part = r_part + 24'd1;
                    end
                    n_fill                 = {1'b0, i_head.length};
                    n_out_word.part_index  = n_part;
                    n_out_word.part_offset = '0;
                    n_out_word.new_part    = 1'b1;
                end else begin
                    n_fill = sum[31:0];
                end
                // End of input starts the next stream at part zero.
                if (i_head.is_final) begin
                    n_fill = '0;
                    n_part = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_part  <= C_MAX_PART_RESET;
            r_fill      <= '0;
            r_part      <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_part <= i_cfg_wr_data;
            end
            r_fill      <= n_fill;
            r_part      <= n_part;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
        end
    end

    `SSS_ASSERT_IMPL(a_new_part_at_zero, i_clk, i_rst_n, r_out_valid && r_out_word.new_part, r_out_word.part_offset == '0)
    `SSS_ASSERT_IMPL(a_error_halts, i_clk, i_rst_n, r_out_valid && r_out_word.status != ST_OK, r_halted)
    `SSS_ASSERT_NEXT(a_halt_sticks, i_clk, i_rst_n, r_halted, r_halted)

endmodule
